FILE: src/s3x_pkg.sv
// ----------------------------------------------------------------------------
// s3x_pkg: shared types and constants of the 3x pixel-art scaler
// Pixel, position and neighbourhood types, register indexes and frame limits.
// ----------------------------------------------------------------------------
package s3x_pkg;

  // Fixed field widths
  localparam int unsigned PixW = 24;
  localparam int unsigned PosW = 8;
  localparam int unsigned DimW = 9;

  // Largest frame, in source pixels
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned AddrW     = $clog2(MaxWidth);

  typedef logic [PixW-1:0] pix_t;
  typedef logic [DimW-1:0] dim_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  // Source position of one pixel
  typedef struct packed {
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
  } pos_t;

  // 3x3 neighbourhood, e is the centre
  typedef struct packed {
    pix_t a;
    pix_t b;
    pix_t c;
    pix_t d;
    pix_t e;
    pix_t f;
    pix_t g;
    pix_t h;
    pix_t i;
  } nbhd_t;

  // Upscaled 3x3 block, sub-pixels E0 to E8
  typedef struct packed {
    pix_t e0;
    pix_t e1;
    pix_t e2;
    pix_t e3;
    pix_t e4;
    pix_t e5;
    pix_t e6;
    pix_t e7;
    pix_t e8;
  } blk_t;

endpackage

FILE: src/s3x_if.sv
// ----------------------------------------------------------------------------
// s3x_if: channel interfaces of the 3x pixel-art scaler
// Source pixel stream, upscaled block stream and register write channel.
// ----------------------------------------------------------------------------

// Source pixel stream
interface s3x_pix_if;
  logic            valid;
  logic            ready;
  logic            start_of_frame;
  s3x_pkg::pix_t   pixel;

  modport source (output valid, output start_of_frame, output pixel, input ready);
  modport sink   (input valid, input start_of_frame, input pixel, output ready);
endinterface

// Upscaled block stream
interface s3x_blk_if;
  logic                        valid;
  logic                        ready;
  logic [s3x_pkg::PosW-1:0]    center_x;
  logic [s3x_pkg::PosW-1:0]    center_y;
  s3x_pkg::pix_t               sub_top_left;
  s3x_pkg::pix_t               sub_top_mid;
  s3x_pkg::pix_t               sub_top_right;
  s3x_pkg::pix_t               sub_mid_left;
  s3x_pkg::pix_t               sub_centre;
  s3x_pkg::pix_t               sub_mid_right;
  s3x_pkg::pix_t               sub_bottom_left;
  s3x_pkg::pix_t               sub_bottom_mid;
  s3x_pkg::pix_t               sub_bottom_right;

  modport source (
    output valid, output center_x, output center_y,
    output sub_top_left, output sub_top_mid, output sub_top_right,
    output sub_mid_left, output sub_centre, output sub_mid_right,
    output sub_bottom_left, output sub_bottom_mid, output sub_bottom_right,
    input  ready
  );
  modport sink (
    input  valid, input center_x, input center_y,
    input  sub_top_left, input sub_top_mid, input sub_top_right,
    input  sub_mid_left, input sub_centre, input sub_mid_right,
    input  sub_bottom_left, input sub_bottom_mid, input sub_bottom_right,
    output ready
  );
endinterface

// Register write channel
interface s3x_cfg_if;
  logic                valid;
  logic                ready;
  s3x_pkg::cfg_idx_e   index;
  s3x_pkg::dim_t       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/scale3x_pixel_scaler_top.sv
// ----------------------------------------------------------------------------
// scale3x_pixel_scaler_top: streaming Scale3x 3x pixel-art upscaler
// Raster pixels in, one upscaled 3x3 block out per interior source pixel.
// ----------------------------------------------------------------------------
// Source pixels enter one per clock in raster order unless the output stalls;
// each pixel at column c >= 2 and row r >= 2 completes the neighbourhood of
// (c-1, r-1) and yields one block, border pixels yield nothing. A pixel passes
// the input stage, where the two line-store memories deliver the rows above,
// then the result register; with the output taken every cycle, a pixel is
// accepted on every clock. Frame width and height are taken as 3 to 256; the
// user must write them only while the block is idle, which the block does not
// enforce. Start of frame restarts the position at the origin; otherwise frames
// follow on by themselves. The line stores need no clearing after reset.
module scale3x_pixel_scaler_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  s3x_cfg_if.sink    cfg_i,
  s3x_pix_if.sink    pix_i,
  s3x_blk_if.source  blk_o
);

  logic                        accept;
  s3x_pkg::pos_t               pos;

  logic                        s1_valid_q;
  s3x_pkg::pos_t               s1_pos_q;
  s3x_pkg::pix_t               s1_px_q;
  logic                        s1_emit, s1_fire;

  s3x_pkg::pix_t               win_q [6];
  s3x_pkg::pix_t               top, mid;
  s3x_pkg::nbhd_t              nb;
  s3x_pkg::blk_t               blk;

  logic                        blk_valid_q;
  logic [s3x_pkg::PosW-1:0]    cx_q, cy_q;
  s3x_pkg::blk_t               blk_q;

  // Input handshake
  assign accept      = pix_i.valid && pix_i.ready;
  assign pix_i.ready = !s1_valid_q || s1_fire;

  s3x_pos_counter u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .adv_i  (accept),
    .sof_i  (pix_i.start_of_frame),
    .pos_o  (pos)
  );

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q <= pos;
      s1_px_q  <= pix_i.pixel;
    end
  end

  // Retire the stage unless a block has nowhere to go
  assign s1_emit = (s1_pos_q.col >= s3x_pkg::PosW'(2)) && (s1_pos_q.row >= s3x_pkg::PosW'(2));
  assign s1_fire = s1_valid_q && (!s1_emit || !blk_valid_q || blk_o.ready);

  s3x_line_buffer u_lines (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (s3x_pkg::AddrW'(pos.col)),
    .wr_en_i    (s1_fire),
    .wr_addr_i  (s3x_pkg::AddrW'(s1_pos_q.col)),
    .wr_upper_i (mid),
    .wr_lower_i (s1_px_q),
    .upper_o    (top),
    .lower_o    (mid)
  );

  // Shift the two-column window left as each pixel retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_fire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_px_q;
    end
  end

  assign nb = '{a: win_q[0], b: win_q[3], c: top,
                d: win_q[1], e: win_q[4], f: mid,
                g: win_q[2], h: win_q[5], i: s1_px_q};

  s3x_edge_rules u_rules (
    .nb_i  (nb),
    .blk_o (blk)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      blk_valid_q <= 1'b1;
    end else if (blk_o.ready) begin
      blk_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit) begin
      cx_q  <= s1_pos_q.col - s3x_pkg::PosW'(1);
      cy_q  <= s1_pos_q.row - s3x_pkg::PosW'(1);
      blk_q <= blk;
    end
  end

  assign blk_o.valid            = blk_valid_q;
  assign blk_o.center_x         = cx_q;
  assign blk_o.center_y         = cy_q;
  assign blk_o.sub_top_left     = blk_q.e0;
  assign blk_o.sub_top_mid      = blk_q.e1;
  assign blk_o.sub_top_right    = blk_q.e2;
  assign blk_o.sub_mid_left     = blk_q.e3;
  assign blk_o.sub_centre       = blk_q.e4;
  assign blk_o.sub_mid_right    = blk_q.e5;
  assign blk_o.sub_bottom_left  = blk_q.e6;
  assign blk_o.sub_bottom_mid   = blk_q.e7;
  assign blk_o.sub_bottom_right = blk_q.e8;

  // A block centre never lies on the top row or left column
  a_centre_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_o.valid |-> (blk_o.center_x != '0) && (blk_o.center_y != '0))
    else $error("block centre on frame border");

  // An accepted pixel always lands in the input stage
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel lost");

  // A retiring interior pixel always leaves a block behind
  a_emit_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_emit) |=> blk_valid_q)
    else $error("interior pixel produced no block");

endmodule

FILE: src/s3x_pos_counter.sv
// ----------------------------------------------------------------------------
// s3x_pos_counter: frame registers and raster position counters
// Holds frame width and height and tracks the column and row of the next pixel.
// ----------------------------------------------------------------------------
module s3x_pos_counter (
  input  logic                clk_i,
  input  logic                rst_ni,
  s3x_cfg_if.sink             cfg_i,
  input  logic                adv_i,
  input  logic                sof_i,
  output s3x_pkg::pos_t       pos_o
);

  s3x_pkg::dim_t                 frame_width_q, frame_height_q;
  s3x_pkg::dim_t                 width_lim, height_lim;
  logic [s3x_pkg::PosW-1:0]      col_q, col_d, row_q, row_d;
  logic [s3x_pkg::PosW-1:0]      cur_col, cur_row;
  s3x_pkg::dim_t                 col_inc, row_inc;
  logic                          last_col, last_row;

  // Register writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= s3x_pkg::DimW'(160);
      frame_height_q <= s3x_pkg::DimW'(144);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        s3x_pkg::CfgFrameWidth:  frame_width_q  <= cfg_i.data;
        s3x_pkg::CfgFrameHeight: frame_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size into the supported range
  always_comb begin
    if (frame_width_q < s3x_pkg::DimW'(3)) begin
      width_lim = s3x_pkg::DimW'(3);
    end else if (frame_width_q > s3x_pkg::DimW'(s3x_pkg::MaxWidth)) begin
      width_lim = s3x_pkg::DimW'(s3x_pkg::MaxWidth);
    end else begin
      width_lim = frame_width_q;
    end
    if (frame_height_q < s3x_pkg::DimW'(3)) begin
      height_lim = s3x_pkg::DimW'(3);
    end else if (frame_height_q > s3x_pkg::DimW'(s3x_pkg::MaxHeight)) begin
      height_lim = s3x_pkg::DimW'(s3x_pkg::MaxHeight);
    end else begin
      height_lim = frame_height_q;
    end
  end

  // Position of the pixel in this transaction; start of frame restarts at the origin
  assign cur_col = sof_i ? '0 : col_q;
  assign cur_row = sof_i ? '0 : row_q;
  assign pos_o   = '{col: cur_col, row: cur_row};

  // Advance, wrapping at the end of a row and of the frame
  assign col_inc  = {1'b0, cur_col} + s3x_pkg::DimW'(1);
  assign row_inc  = {1'b0, cur_row} + s3x_pkg::DimW'(1);
  assign last_col = col_inc >= width_lim;
  assign last_row = row_inc >= height_lim;

  always_comb begin
    col_d = col_inc[s3x_pkg::PosW-1:0];
    row_d = cur_row;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_inc[s3x_pkg::PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (adv_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: src/s3x_line_buffer.sv
// ----------------------------------------------------------------------------
// s3x_line_buffer: two line stores for the rows above the current one
// Read at accept time with registered data, written once the pixel is processed.
// ----------------------------------------------------------------------------
module s3x_line_buffer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [s3x_pkg::AddrW-1:0]   rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [s3x_pkg::AddrW-1:0]   wr_addr_i,
  input  s3x_pkg::pix_t               wr_upper_i,
  input  s3x_pkg::pix_t               wr_lower_i,
  output s3x_pkg::pix_t               upper_o,
  output s3x_pkg::pix_t               lower_o
);

  s3x_pkg::pix_t  mem_upper_q [s3x_pkg::MaxWidth];
  s3x_pkg::pix_t  mem_lower_q [s3x_pkg::MaxWidth];
  s3x_pkg::pix_t  rd_upper_q, rd_lower_q;
  s3x_pkg::pix_t  byp_upper_q, byp_lower_q;
  logic           byp_q;

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_upper_q[wr_addr_i] <= wr_upper_i;
      mem_lower_q[wr_addr_i] <= wr_lower_i;
    end
    if (rd_en_i) begin
      rd_upper_q <= mem_upper_q[rd_addr_i];
      rd_lower_q <= mem_lower_q[rd_addr_i];
    end
  end

  // Catch a write to the entry being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_upper_q <= wr_upper_i;
      byp_lower_q <= wr_lower_i;
    end
  end

  assign upper_o = byp_q ? byp_upper_q : rd_upper_q;
  assign lower_o = byp_q ? byp_lower_q : rd_lower_q;

endmodule

FILE: src/s3x_edge_rules.sv
// ----------------------------------------------------------------------------
// s3x_edge_rules: Scale3x equality rules
// Turns one 3x3 neighbourhood into the 3x3 upscaled block of its centre.
// ----------------------------------------------------------------------------
module s3x_edge_rules (
  input  s3x_pkg::nbhd_t  nb_i,
  output s3x_pkg::blk_t   blk_o
);

  logic db, bf, dh, hf;
  logic ul, ur, dl, dr;

  // Edge equalities around the centre
  assign db = nb_i.d == nb_i.b;
  assign bf = nb_i.b == nb_i.f;
  assign dh = nb_i.d == nb_i.h;
  assign hf = nb_i.h == nb_i.f;

  // Corner rules
  assign ul = db && !bf && !dh;
  assign ur = bf && !db && !hf;
  assign dl = dh && !db && !hf;
  assign dr = hf && !dh && !bf;

  // Pick each sub-pixel
  always_comb begin
    blk_o.e0 = ul ? nb_i.d : nb_i.e;
    blk_o.e1 = ((ul && nb_i.e != nb_i.c) || (ur && nb_i.e != nb_i.a)) ? nb_i.b : nb_i.e;
    blk_o.e2 = ur ? nb_i.f : nb_i.e;
    blk_o.e3 = ((ul && nb_i.e != nb_i.g) || (dl && nb_i.e != nb_i.a)) ? nb_i.d : nb_i.e;
    blk_o.e4 = nb_i.e;
    blk_o.e5 = ((ur && nb_i.e != nb_i.i) || (dr && nb_i.e != nb_i.c)) ? nb_i.f : nb_i.e;
    blk_o.e6 = dl ? nb_i.d : nb_i.e;
    blk_o.e7 = ((dl && nb_i.e != nb_i.i) || (dr && nb_i.e != nb_i.g)) ? nb_i.h : nb_i.e;
    blk_o.e8 = dr ? nb_i.f : nb_i.e;
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the streaming 3x pixel-art scaler
// Feeds raster pixels, mostly as whole frames of a few repeated colours, and
// predicts every upscaled block from its own copy of the line stores, window
// and counters. The frame size is changed between phases, including the
// clamped extremes. Either side idles or stalls at random, depending on phase.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 300;

  localparam s3x_pkg::pix_t ColBlack = 24'h000000;
  localparam s3x_pkg::pix_t ColWhite = 24'hFFFFFF;
  localparam s3x_pkg::pix_t ColBlue  = 24'h5A3C96;
  localparam s3x_pkg::pix_t ColAmber = 24'hA5C369;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSrc,
    IdleSink,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    logic          sof;
    s3x_pkg::pix_t px;
  } src_pix_t;

  typedef struct packed {
    logic [s3x_pkg::PosW-1:0] cx;
    logic [s3x_pkg::PosW-1:0] cy;
    s3x_pkg::blk_t            sub;
  } block_rec_t;

  logic clk_i;
  logic rst_ni;

  s3x_cfg_if cfg_if ();
  s3x_pix_if pix_if ();
  s3x_blk_if blk_if ();

  scale3x_pixel_scaler_top dut (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg_if),
    .pix_i (pix_if),
    .blk_o (blk_if)
  );

  // Scaler state as the bench sees it
  s3x_pkg::dim_t width_reg;
  s3x_pkg::dim_t height_reg;
  s3x_pkg::pix_t upper_line [s3x_pkg::MaxWidth];
  s3x_pkg::pix_t lower_line [s3x_pkg::MaxWidth];
  s3x_pkg::pix_t win_cols [6];
  int unsigned   col_pos;
  int unsigned   row_pos;

  block_rec_t  expected_blocks [$];
  src_pix_t    pixel_queue [$];
  src_pix_t    bus_pixel;

  idle_mode_e    idle_mode;
  logic          hold_arm;
  logic          hold_used;
  int unsigned   hold_left;
  s3x_pkg::pix_t palette [4];
  int unsigned   n_colours;
  int unsigned   fail_count;
  int unsigned   cycle_count;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(s3x_pkg::dim_t v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the scaler state by one pixel and queue the block it completes
  function automatic void predict_pixel(src_pix_t item);
    int unsigned     w, h, c, r;
    s3x_pkg::nbhd_t  nb;
    logic            db, bf, dh, hf, ul, ur, dl, dr;
    block_rec_t      rec;
    w = clamp_dim(width_reg, s3x_pkg::MaxWidth);
    h = clamp_dim(height_reg, s3x_pkg::MaxHeight);
    if (item.sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= s3x_pkg::MaxWidth) col_pos = 0;
    c = col_pos;
    r = row_pos;
    nb.a = win_cols[0];
    nb.d = win_cols[1];
    nb.g = win_cols[2];
    nb.b = win_cols[3];
    nb.e = win_cols[4];
    nb.h = win_cols[5];
    nb.c = upper_line[c];
    nb.f = lower_line[c];
    nb.i = item.px;
    if (c >= 2 && r >= 2) begin
      db = (nb.d == nb.b);
      bf = (nb.b == nb.f);
      dh = (nb.d == nb.h);
      hf = (nb.h == nb.f);
      ul = db && !bf && !dh;
      ur = bf && !db && !hf;
      dl = dh && !db && !hf;
      dr = hf && !dh && !bf;
      rec.cx     = s3x_pkg::PosW'(c - 1);
      rec.cy     = s3x_pkg::PosW'(r - 1);
      rec.sub.e0 = ul ? nb.d : nb.e;
      rec.sub.e1 = ((ul && nb.e != nb.c) || (ur && nb.e != nb.a)) ? nb.b : nb.e;
      rec.sub.e2 = ur ? nb.f : nb.e;
      rec.sub.e3 = ((ul && nb.e != nb.g) || (dl && nb.e != nb.a)) ? nb.d : nb.e;
      rec.sub.e4 = nb.e;
      rec.sub.e5 = ((ur && nb.e != nb.i) || (dr && nb.e != nb.c)) ? nb.f : nb.e;
      rec.sub.e6 = dl ? nb.d : nb.e;
      rec.sub.e7 = ((dl && nb.e != nb.i) || (dr && nb.e != nb.g)) ? nb.h : nb.e;
      rec.sub.e8 = dr ? nb.f : nb.e;
      expected_blocks.push_back(rec);
    end
    // shift the window one column left
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = nb.c;
    win_cols[4] = nb.f;
    win_cols[5] = nb.i;
    upper_line[c] = nb.f;
    lower_line[c] = nb.i;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic bit roll_gap(idle_mode_e side);
    if (idle_mode == side) return $urandom_range(99) < 72;
    if (idle_mode == IdleBoth) return $urandom_range(99) < 16;
    return 1'b0;
  endfunction

  function automatic s3x_pkg::pix_t pick_colour();
    if ($urandom_range(99) < 15) return s3x_pkg::pix_t'($urandom());
    return palette[$urandom_range(n_colours - 1)];
  endfunction

  function automatic void check_field(string name, logic [s3x_pkg::PixW-1:0] want,
                                      logic [s3x_pkg::PixW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %06h, got %06h", name, want, got);
      fail_count++;
    end
  endfunction

  // Pixel driver: predict on each transaction, then offer the next pixel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid          <= 1'b0;
      pix_if.start_of_frame <= 1'b0;
      pix_if.pixel          <= '0;
    end else begin
      if (pix_if.valid && pix_if.ready) predict_pixel(bus_pixel);
      if (!pix_if.valid || pix_if.ready) begin
        if (pixel_queue.size() != 0 && !roll_gap(IdleSrc)) begin
          bus_pixel = pixel_queue.pop_front();
          pix_if.valid          <= 1'b1;
          pix_if.start_of_frame <= bus_pixel.sof;
          pix_if.pixel          <= bus_pixel.px;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Block monitor: compare each transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    block_rec_t want;
    if (!rst_ni) begin
      blk_if.ready <= 1'b0;
    end else begin
      if (blk_if.valid && blk_if.ready) begin
        if (expected_blocks.size() == 0) begin
          $error("block at (%0d,%0d) with no pixel to account for it",
                 blk_if.center_x, blk_if.center_y);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          check_field("center_x", want.cx, blk_if.center_x);
          check_field("center_y", want.cy, blk_if.center_y);
          check_field("sub_top_left", want.sub.e0, blk_if.sub_top_left);
          check_field("sub_top_mid", want.sub.e1, blk_if.sub_top_mid);
          check_field("sub_top_right", want.sub.e2, blk_if.sub_top_right);
          check_field("sub_mid_left", want.sub.e3, blk_if.sub_mid_left);
          check_field("sub_centre", want.sub.e4, blk_if.sub_centre);
          check_field("sub_mid_right", want.sub.e5, blk_if.sub_mid_right);
          check_field("sub_bottom_left", want.sub.e6, blk_if.sub_bottom_left);
          check_field("sub_bottom_mid", want.sub.e7, blk_if.sub_bottom_mid);
          check_field("sub_bottom_right", want.sub.e8, blk_if.sub_bottom_right);
        end
      end
      blk_if.ready <= (hold_left == 0) && !roll_gap(IdleSink);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Write both frame dimensions; call only while the scaler is idle
  task automatic write_dims(s3x_pkg::dim_t w, s3x_pkg::dim_t h);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= s3x_pkg::CfgFrameWidth;
    cfg_if.data  <= w;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    width_reg = w;
    cfg_if.index <= s3x_pkg::CfgFrameHeight;
    cfg_if.data  <= h;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    height_reg = h;
    cfg_if.valid <= 1'b0;
  endtask

  // Hold until every pixel is taken and every block has arrived
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_queue.size() != 0 || pix_if.valid || expected_blocks.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic push_pixel(logic sof, s3x_pkg::pix_t px);
    src_pix_t item;
    item.sof = sof;
    item.px  = px;
    pixel_queue.push_back(item);
  endtask

  // Mostly whole frames, the rest short runs with stray frame starts
  task automatic queue_frames(int unsigned n_items, int unsigned w, int unsigned h);
    int unsigned pushed;
    int unsigned run;
    pushed = 0;
    while (pushed < n_items) begin
      if (pushed == 0 || $urandom_range(99) < 85) begin
        for (int unsigned k = 0; k < w * h; k++) push_pixel(k == 0, pick_colour());
        pushed += w * h;
      end else begin
        run = $urandom_range(2 * w, 1);
        repeat (run) push_pixel($urandom_range(7) == 0, pick_colour());
        pushed += run;
      end
    end
  endtask

  task automatic run_phase(idle_mode_e mode, s3x_pkg::dim_t w_cfg, s3x_pkg::dim_t h_cfg,
                           int unsigned n_items, bit carry_on, bit with_hold);
    int unsigned w, h;
    bit          grows;
    wait_idle();
    grows = clamp_dim(w_cfg, s3x_pkg::MaxWidth) > clamp_dim(width_reg, s3x_pkg::MaxWidth);
    write_dims(w_cfg, h_cfg);
    w = clamp_dim(w_cfg, s3x_pkg::MaxWidth);
    h = clamp_dim(h_cfg, s3x_pkg::MaxHeight);
    @(negedge clk_i);
    idle_mode = mode;
    n_colours = $urandom_range(4, 2);
    foreach (palette[k]) palette[k] = s3x_pkg::pix_t'($urandom());
    if ($urandom_range(1) == 0) begin
      palette[0] = ColBlack;
      palette[1] = ColWhite;
    end
    // carry on mid-frame only where every line-store column read was written
    if (carry_on && !grows) repeat (2 * w) push_pixel(1'b0, pick_colour());
    queue_frames(n_items, w, h);
    if (with_hold) hold_arm = 1'b1;
  endtask

  // Hand-made 3x3 frames for each corner rule, then restart and wrap
  task automatic queue_directed();
    s3x_pkg::pix_t rules_a [9];
    s3x_pkg::pix_t rules_b [9];
    s3x_pkg::pix_t chequer [9];
    rules_a = '{ColBlack, ColBlue, ColBlack, ColBlue, ColWhite, ColAmber,
                ColBlack, ColAmber, ColBlack};
    rules_b = '{ColWhite, ColBlue, ColWhite, ColAmber, ColBlack, ColBlue,
                ColWhite, ColAmber, ColWhite};
    chequer = '{ColWhite, ColBlack, ColWhite, ColBlack, ColWhite, ColBlack,
                ColWhite, ColBlack, ColWhite};
    // up-left with down-right
    foreach (rules_a[k]) push_pixel(k == 0, rules_a[k]);
    // partial frame cut short by a new frame start
    push_pixel(1'b0, ColWhite);
    push_pixel(1'b0, ColBlack);
    // up-right with down-left
    foreach (rules_b[k]) push_pixel(k == 0, rules_b[k]);
    // edge neighbours all alike, entered by frame wrap alone
    foreach (chequer[k]) push_pixel(1'b0, chequer[k]);
  endtask

  initial begin
    idle_mode             = IdleNone;
    hold_arm              = 1'b0;
    fail_count            = 0;
    cycle_count           = 0;
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = s3x_pkg::CfgFrameWidth;
    cfg_if.data           = '0;
    pix_if.valid          = 1'b0;
    pix_if.start_of_frame = 1'b0;
    pix_if.pixel          = '0;
    blk_if.ready          = 1'b0;
    width_reg             = 9'd160;
    height_reg            = 9'd144;
    col_pos               = 0;
    row_pos               = 0;
    foreach (win_cols[k]) win_cols[k] = '0;
    foreach (upper_line[k]) begin
      upper_line[k] = '0;
      lower_line[k] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest frame from out-of-range low values
    write_dims(9'd0, 9'd2);
    @(negedge clk_i);
    queue_directed();

    run_phase(IdleSrc,  9'd511, 9'd3,   768, 1'b0, 1'b0);
    run_phase(IdleSink, 9'd3,   9'd300, 768, 1'b0, 1'b0);
    run_phase(IdleBoth, 9'd5,   9'd4,    80, 1'b0, 1'b0);
    run_phase(IdleNone, 9'd8,   9'd6,   120, 1'b0, 1'b1);
    run_phase(IdleSrc,  9'd6,   9'd5,    60, 1'b0, 1'b0);
    run_phase(IdleSink, 9'd4,   9'd1,    60, 1'b1, 1'b0);
    run_phase(IdleBoth, 9'd2,   9'd7,    80, 1'b0, 1'b0);

    wait_idle();
    if (fail_count == 0 && expected_blocks.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
